>>> rtl/core/vfss_pkg.sv
package vfss_pkg;

  localparam int SIZE_W  = 24;
  localparam int TOTAL_W = 48;
  localparam int CNT_W   = 32;
  localparam int SECS_W  = 6;
  localparam int STAT_W  = 48;
  localparam int IDX_W   = 5;

  localparam logic [SECS_W-1:0] WIN_SECS_RST = SECS_W'(5);
  localparam logic [SECS_W-1:0] SECS_MAX     = '1;

  typedef enum logic [0:0] {
    CFG_WINDOW_SECONDS = 1'b0,
    CFG_REPORT_ENABLE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    MODE_FRAME = 1'b0,
    MODE_TICK  = 1'b1
  } in_mode_t;

  typedef enum logic [IDX_W-1:0] {
    ST_FRAMES         = 5'd0,
    ST_KEY_FRAMES     = 5'd1,
    ST_DELTA_FRAMES   = 5'd2,
    ST_BYTES          = 5'd3,
    ST_KEY_BYTES      = 5'd4,
    ST_DELTA_BYTES    = 5'd5,
    ST_WIN_FRAMES     = 5'd6,
    ST_WIN_KEY_FRAMES = 5'd7,
    ST_WIN_DLT_FRAMES = 5'd8,
    ST_WIN_BYTES      = 5'd9,
    ST_WIN_KEY_BYTES  = 5'd10,
    ST_WIN_DLT_BYTES  = 5'd11,
    ST_MAX_ANY        = 5'd12,
    ST_MAX_KEY        = 5'd13,
    ST_MAX_DELTA      = 5'd14,
    ST_MIN_ANY        = 5'd15,
    ST_MIN_KEY        = 5'd16,
    ST_MIN_DELTA      = 5'd17,
    ST_MAX_GOP        = 5'd18,
    ST_GOP            = 5'd19
  } stat_idx_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] frames;
    logic [TOTAL_W-1:0] key_frames;
    logic [TOTAL_W-1:0] delta_frames;
    logic [TOTAL_W-1:0] bytes;
    logic [TOTAL_W-1:0] key_bytes;
    logic [TOTAL_W-1:0] delta_bytes;
    logic [CNT_W-1:0]   win_frames;
    logic [CNT_W-1:0]   win_key_frames;
    logic [CNT_W-1:0]   win_delta_frames;
    logic [TOTAL_W-1:0] win_bytes;
    logic [TOTAL_W-1:0] win_key_bytes;
    logic [TOTAL_W-1:0] win_delta_bytes;
    logic [SIZE_W-1:0]  max_any;
    logic [SIZE_W-1:0]  max_key;
    logic [SIZE_W-1:0]  max_delta;
    logic [SIZE_W-1:0]  min_any;
    logic [SIZE_W-1:0]  min_key;
    logic [SIZE_W-1:0]  min_delta;
    logic [CNT_W-1:0]   max_gop;
    logic [CNT_W-1:0]   gop;
  } vfss_stats_t;

  function automatic logic [TOTAL_W-1:0] sat_add_total(input logic [TOTAL_W-1:0] a,
                                                      input logic [SIZE_W-1:0]  b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + (TOTAL_W+1)'(b);
    return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc_total(input logic [TOTAL_W-1:0] a);
    return (&a) ? a : a + TOTAL_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] a);
    return (&a) ? a : a + CNT_W'(1);
  endfunction

endpackage

>>> rtl/core/vfss_accum.sv
module vfss_accum
  import vfss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_addr,
  input  logic [SECS_W-1:0]   cfg_wdata,
  input  logic                beat_acc,
  input  logic                mode,
  input  logic [SIZE_W-1:0]   frame_bytes,
  input  logic                is_delta,
  output logic                rep_start,
  output vfss_stats_t         stats
);

  logic [SECS_W-1:0]  win_secs_r;
  logic               rep_en_r;
  logic [SECS_W-1:0]  secs_r, secs_nxt;

  logic [TOTAL_W-1:0] frames_r, key_frames_r, delta_frames_r;
  logic [TOTAL_W-1:0] bytes_r, key_bytes_r, delta_bytes_r;
  logic [TOTAL_W-1:0] frames_nxt, key_frames_nxt, delta_frames_nxt;
  logic [TOTAL_W-1:0] bytes_nxt, key_bytes_nxt, delta_bytes_nxt;
  logic [CNT_W-1:0]   wfr_r, wkfr_r, wdfr_r, wfr_nxt, wkfr_nxt, wdfr_nxt;
  logic [TOTAL_W-1:0] wby_r, wkby_r, wdby_r, wby_nxt, wkby_nxt, wdby_nxt;
  logic [SIZE_W-1:0]  max_any_r, max_key_r, max_delta_r;
  logic [SIZE_W-1:0]  min_any_r, min_key_r, min_delta_r;
  logic [SIZE_W-1:0]  max_any_nxt, max_key_nxt, max_delta_nxt;
  logic [SIZE_W-1:0]  min_any_nxt, min_key_nxt, min_delta_nxt;
  logic [CNT_W-1:0]   gop_r, max_gop_r, gop_nxt, max_gop_nxt;

  // window counts as of the closing frame, held for the report
  logic [CNT_W-1:0]   snap_wfr_r, snap_wkfr_r, snap_wdfr_r;
  logic [TOTAL_W-1:0] snap_wby_r, snap_wkby_r, snap_wdby_r;

  logic frame_acc, tick_acc, win_close;

  assign frame_acc = beat_acc && (mode == MODE_FRAME);
  assign tick_acc  = beat_acc && (mode == MODE_TICK);
  assign win_close = frame_acc && (secs_r >= win_secs_r);
  assign rep_start = win_close && rep_en_r;

  always_comb begin
    frames_nxt       = frames_r;
    key_frames_nxt   = key_frames_r;
    delta_frames_nxt = delta_frames_r;
    bytes_nxt        = bytes_r;
    key_bytes_nxt    = key_bytes_r;
    delta_bytes_nxt  = delta_bytes_r;
    wfr_nxt          = wfr_r;
    wkfr_nxt         = wkfr_r;
    wdfr_nxt         = wdfr_r;
    wby_nxt          = wby_r;
    wkby_nxt         = wkby_r;
    wdby_nxt         = wdby_r;
    max_any_nxt      = max_any_r;
    max_key_nxt      = max_key_r;
    max_delta_nxt    = max_delta_r;
    min_any_nxt      = min_any_r;
    min_key_nxt      = min_key_r;
    min_delta_nxt    = min_delta_r;
    gop_nxt          = gop_r;
    max_gop_nxt      = max_gop_r;
    secs_nxt         = secs_r;
    if (tick_acc && (secs_r != SECS_MAX)) begin
      secs_nxt = secs_r + SECS_W'(1);
    end
    if (frame_acc) begin
      frames_nxt = sat_inc_total(frames_r);
      bytes_nxt  = sat_add_total(bytes_r, frame_bytes);
      wfr_nxt    = sat_inc_cnt(wfr_r);
      wby_nxt    = sat_add_total(wby_r, frame_bytes);
      if (frame_bytes > max_any_r) max_any_nxt = frame_bytes;
      if (frame_bytes < min_any_r) min_any_nxt = frame_bytes;
      if (is_delta) begin
        delta_frames_nxt = sat_inc_total(delta_frames_r);
        delta_bytes_nxt  = sat_add_total(delta_bytes_r, frame_bytes);
        wdfr_nxt         = sat_inc_cnt(wdfr_r);
        wdby_nxt         = sat_add_total(wdby_r, frame_bytes);
        gop_nxt          = sat_inc_cnt(gop_r);
        if (frame_bytes > max_delta_r) max_delta_nxt = frame_bytes;
        if (frame_bytes < min_delta_r) min_delta_nxt = frame_bytes;
      end else begin
        key_frames_nxt = sat_inc_total(key_frames_r);
        key_bytes_nxt  = sat_add_total(key_bytes_r, frame_bytes);
        wkfr_nxt       = sat_inc_cnt(wkfr_r);
        wkby_nxt       = sat_add_total(wkby_r, frame_bytes);
        if (gop_r > max_gop_r) max_gop_nxt = gop_r;
        gop_nxt = '0;
        if (frame_bytes > max_key_r) max_key_nxt = frame_bytes;
        if (frame_bytes < min_key_r) min_key_nxt = frame_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_secs_r     <= WIN_SECS_RST;
      rep_en_r       <= 1'b1;
      secs_r         <= '0;
      frames_r       <= '0;
      key_frames_r   <= '0;
      delta_frames_r <= '0;
      bytes_r        <= '0;
      key_bytes_r    <= '0;
      delta_bytes_r  <= '0;
      wfr_r          <= '0;
      wkfr_r         <= '0;
      wdfr_r         <= '0;
      wby_r          <= '0;
      wkby_r         <= '0;
      wdby_r         <= '0;
      max_any_r      <= '0;
      max_key_r      <= '0;
      max_delta_r    <= '0;
      min_any_r      <= '1;
      min_key_r      <= '1;
      min_delta_r    <= '1;
      gop_r          <= '0;
      max_gop_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_WINDOW_SECONDS: win_secs_r <= cfg_wdata;
          CFG_REPORT_ENABLE:  rep_en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      frames_r       <= frames_nxt;
      key_frames_r   <= key_frames_nxt;
      delta_frames_r <= delta_frames_nxt;
      bytes_r        <= bytes_nxt;
      key_bytes_r    <= key_bytes_nxt;
      delta_bytes_r  <= delta_bytes_nxt;
      max_any_r      <= max_any_nxt;
      max_key_r      <= max_key_nxt;
      max_delta_r    <= max_delta_nxt;
      min_any_r      <= min_any_nxt;
      min_key_r      <= min_key_nxt;
      min_delta_r    <= min_delta_nxt;
      gop_r          <= gop_nxt;
      max_gop_r      <= max_gop_nxt;
      if (win_close) begin
        secs_r <= '0;
        wfr_r  <= '0;
        wkfr_r <= '0;
        wdfr_r <= '0;
        wby_r  <= '0;
        wkby_r <= '0;
        wdby_r <= '0;
      end else begin
        secs_r <= secs_nxt;
        wfr_r  <= wfr_nxt;
        wkfr_r <= wkfr_nxt;
        wdfr_r <= wdfr_nxt;
        wby_r  <= wby_nxt;
        wkby_r <= wkby_nxt;
        wdby_r <= wdby_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_close) begin
      snap_wfr_r  <= wfr_nxt;
      snap_wkfr_r <= wkfr_nxt;
      snap_wdfr_r <= wdfr_nxt;
      snap_wby_r  <= wby_nxt;
      snap_wkby_r <= wkby_nxt;
      snap_wdby_r <= wdby_nxt;
    end
  end

  // totals, extremes and runs are frozen while a report drains
  always_comb begin
    stats.frames           = frames_r;
    stats.key_frames       = key_frames_r;
    stats.delta_frames     = delta_frames_r;
    stats.bytes            = bytes_r;
    stats.key_bytes        = key_bytes_r;
    stats.delta_bytes      = delta_bytes_r;
    stats.win_frames       = snap_wfr_r;
    stats.win_key_frames   = snap_wkfr_r;
    stats.win_delta_frames = snap_wdfr_r;
    stats.win_bytes        = snap_wby_r;
    stats.win_key_bytes    = snap_wkby_r;
    stats.win_delta_bytes  = snap_wdby_r;
    stats.max_any          = max_any_r;
    stats.max_key          = max_key_r;
    stats.max_delta        = max_delta_r;
    stats.min_any          = min_any_r;
    stats.min_key          = min_key_r;
    stats.min_delta        = min_delta_r;
    stats.max_gop          = max_gop_r;
    stats.gop              = gop_r;
  end

endmodule

>>> rtl/core/vfss_report.sv
module vfss_report
  import vfss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rep_start,
  input  vfss_stats_t        stats,
  output logic               busy,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [STAT_W-1:0]  out_tdata,
  output logic [IDX_W-1:0]   out_tuser,
  output logic               out_tlast
);

  logic              busy_r;
  logic [IDX_W-1:0]  idx_r;
  logic              ovalid_r;
  logic [IDX_W-1:0]  oidx_r;
  logic [STAT_W-1:0] oval_r;
  logic              olast_r;
  logic [STAT_W-1:0] sel_val;
  logic              load;
  logic              at_last;

  assign at_last = (idx_r == ST_GOP);
  assign load    = busy_r && (!ovalid_r || out_tready);

  always_comb begin
    case (idx_r)
      ST_FRAMES:         sel_val = stats.frames;
      ST_KEY_FRAMES:     sel_val = stats.key_frames;
      ST_DELTA_FRAMES:   sel_val = stats.delta_frames;
      ST_BYTES:          sel_val = stats.bytes;
      ST_KEY_BYTES:      sel_val = stats.key_bytes;
      ST_DELTA_BYTES:    sel_val = stats.delta_bytes;
      ST_WIN_FRAMES:     sel_val = STAT_W'(stats.win_frames);
      ST_WIN_KEY_FRAMES: sel_val = STAT_W'(stats.win_key_frames);
      ST_WIN_DLT_FRAMES: sel_val = STAT_W'(stats.win_delta_frames);
      ST_WIN_BYTES:      sel_val = stats.win_bytes;
      ST_WIN_KEY_BYTES:  sel_val = stats.win_key_bytes;
      ST_WIN_DLT_BYTES:  sel_val = stats.win_delta_bytes;
      ST_MAX_ANY:        sel_val = STAT_W'(stats.max_any);
      ST_MAX_KEY:        sel_val = STAT_W'(stats.max_key);
      ST_MAX_DELTA:      sel_val = STAT_W'(stats.max_delta);
      ST_MIN_ANY:        sel_val = STAT_W'(stats.min_any);
      ST_MIN_KEY:        sel_val = STAT_W'(stats.min_key);
      ST_MIN_DELTA:      sel_val = STAT_W'(stats.min_delta);
      ST_MAX_GOP:        sel_val = STAT_W'(stats.max_gop);
      ST_GOP:            sel_val = STAT_W'(stats.gop);
      default:           sel_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (rep_start) begin
        busy_r <= 1'b1;
        idx_r  <= ST_FRAMES;
      end else if (load) begin
        busy_r <= !at_last;
        idx_r  <= idx_r + IDX_W'(1);
      end
      if (load) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oidx_r  <= idx_r;
      oval_r  <= sel_val;
      olast_r <= at_last;
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = oidx_r;
  assign out_tlast  = olast_r;

endmodule

>>> rtl/core/video_frame_stream_statistics_core.sv
// Video frame stream statistics core.
// Input stream: one beat per frame or per passing second. in_tuser is the
// mode (0 frame, 1 second tick); in_tdata carries frame_bytes and is_delta.
// Output stream: a report of 20 beats, one statistic each; in_tuser-style
// out_tuser holds the statistic index, out_tdata its 48-bit value, and
// out_tlast marks statistic 19.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata; 0 = window_seconds,
// 1 = report_enable. Write only while the block is idle.
// Throughput: one input beat per cycle. A frame that closes the window with
// reporting on starts a report; the input is held off (in_tready low) from
// the next cycle until the report's last beat has entered the single
// output register. The first beat enters that register once busy is set
// by the closing frame; it is later only while an earlier last beat still
// waits. Output stalls hold the report and, through it, the input.
// Reset (rst_n low, synchronous): counters clear, minimums go to all ones,
// window_seconds returns to 5 and report_enable to 1; no beat is pending
// and in_tready stays low.
module video_frame_stream_statistics_core
  import vfss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_addr,
  input  logic [SECS_W-1:0]  cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,    // [23:0] frame_bytes, [24] is_delta, rest zero
  input  logic [0:0]         in_tuser,    // [0] mode
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [STAT_W-1:0]  out_tdata,   // [47:0] stat_value
  output logic [IDX_W-1:0]   out_tuser,   // [4:0] stat_index
  output logic               out_tlast    // last_of_run
);

  logic        beat_acc;
  logic        rep_start;
  logic        busy;
  vfss_stats_t stats;

  assign in_tready = rst_n && !busy;
  assign beat_acc  = in_tvalid && in_tready;

  vfss_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .beat_acc    (beat_acc),
    .mode        (in_tuser[0]),
    .frame_bytes (in_tdata[SIZE_W-1:0]),
    .is_delta    (in_tdata[SIZE_W]),
    .rep_start   (rep_start),
    .stats       (stats)
  );

  vfss_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .rep_start  (rep_start),
    .stats      (stats),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rep_start |=> busy && !in_tready)
    else $error("report start did not hold off input");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == ST_GOP)))
    else $error("tlast does not match final statistic");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser == $past(out_tuser) + IDX_W'(1)))
    else $error("report beats not consecutive");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !rep_start)
    else $error("report started while one is draining");

endmodule
